### hdl/arpe_pkg.sv
// ----------------------------------------------------------------------------
// arpe_pkg
// Shared types, character codes and limits for the AT response payload
// extractor.
// ----------------------------------------------------------------------------
package arpe_pkg;

	// Largest store supported; the count registers are sized for it
	localparam int PAYLOAD_DEPTH_DEF = 64;
	localparam int PAYLOAD_DEPTH_MAX = 64;
	localparam int CNT_W             = $clog2(PAYLOAD_DEPTH_MAX + 1);
	localparam int REGION_W          = 8;

	// Character codes
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_K     = 8'h4B;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// Parse phases
	localparam logic [1:0] PH_SEEK    = 2'd0;
	localparam logic [1:0] PH_CAPTURE = 2'd1;
	localparam logic [1:0] PH_STOPPED = 2'd2;

	// Lead pattern tracking
	localparam logic [2:0] LEAD_MATCHED = 3'd3;
	localparam logic [2:0] LEAD_FAILED  = 3'd7;

	// Terminator progress needed before the final LF
	localparam logic [2:0] TERM_LAST = 3'd3;

	// Burst request from the parser to the emitter
	typedef struct packed {
		logic             start;
		logic             lead;
		logic [CNT_W-1:0] cnt;
	} burst_t;

	// Expected byte of "OK" CR LF at a given progress
	function automatic logic [7:0] term_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = CH_O;
			3'd1:    c = CH_K;
			3'd2:    c = CH_CR;
			default: c = CH_LF;
		endcase
		return c;
	endfunction

	// Expected byte of the LF CR LF lead pattern
	function automatic logic [7:0] lead_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd1:    c = CH_CR;
			default: c = CH_LF;
		endcase
		return c;
	endfunction

endpackage

### hdl/arpe_ram.sv
// ----------------------------------------------------------------------------
// arpe_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module arpe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

### hdl/arpe_parser.sv
// ----------------------------------------------------------------------------
// arpe_parser
// Byte-level parser: tracks the terminator, the colon, the lead pattern and
// writes captured bytes into the payload store. Raises a burst request when
// the terminator completes after a colon, if there is a lead or payload.
// ----------------------------------------------------------------------------
module arpe_parser #(
	parameter int PAYLOAD_DEPTH = arpe_pkg::PAYLOAD_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [7:0]                       rx_byte,
	output logic                             wr_en,
	output logic [$clog2(PAYLOAD_DEPTH)-1:0] wr_addr,
	output logic [7:0]                       wr_data,
	output arpe_pkg::burst_t                 burst
);

	import arpe_pkg::*;

	localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);

	logic [1:0]          phase_q, phase_nxt;
	logic [2:0]          ok_q, ok_nxt;
	logic [CNT_W-1:0]    stored_q, stored_nxt;
	logic [REGION_W-1:0] region_q, region_nxt;
	logic [2:0]          lead_q, lead_nxt;
	logic                done;
	logic                is_stop;
	logic [REGION_W-1:0] avail;
	logic [CNT_W-1:0]    cnt;

	assign is_stop = (rx_byte == CH_CR) || (rx_byte == CH_LF) || (rx_byte == CH_NUL);

	// Next-state logic for one received word
	always_comb begin
		phase_nxt  = phase_q;
		stored_nxt = stored_q;
		region_nxt = region_q;
		lead_nxt   = lead_q;
		wr_en      = 1'b0;

		// terminator match; only 'O' can restart a partial match
		if (rx_byte == term_char(ok_q)) begin
			ok_nxt = ok_q + 3'd1;
		end else begin
			ok_nxt = (rx_byte == CH_O) ? 3'd1 : 3'd0;
		end
		done = (rx_byte == term_char(ok_q)) && (ok_q == TERM_LAST);

		if (phase_q == PH_SEEK) begin
			if (rx_byte == CH_COLON) begin
				phase_nxt = PH_CAPTURE;
			end
		end else begin
			if (region_q != '1) begin
				region_nxt = region_q + REGION_W'(1);
			end
			if (lead_q < LEAD_MATCHED) begin
				lead_nxt = (rx_byte == lead_char(lead_q)) ? lead_q + 3'd1 : LEAD_FAILED;
			end
			if (phase_q == PH_CAPTURE) begin
				if (is_stop) begin
					phase_nxt = PH_STOPPED;
				end else if (stored_q < CNT_W'(PAYLOAD_DEPTH)) begin
					wr_en      = accept;
					stored_nxt = stored_q + CNT_W'(1);
				end
			end
		end
	end

	assign wr_addr = stored_q[ADDR_W-1:0];
	assign wr_data = rx_byte;

	// Bytes before the terminator: region minus "OK" CR LF, capped by store
	assign avail = (region_nxt >= REGION_W'(4)) ? region_nxt - REGION_W'(4) : '0;
	assign cnt   = (REGION_W'(stored_nxt) > avail) ? avail[CNT_W-1:0] : stored_nxt;

	always_comb begin
		burst.lead  = (lead_nxt == LEAD_MATCHED);
		burst.cnt   = cnt;
		burst.start = accept && done && (phase_q != PH_SEEK) &&
			(burst.lead || (cnt != '0));
	end

	// Parser state; terminator restarts everything
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEEK;
			ok_q     <= '0;
			stored_q <= '0;
			region_q <= '0;
			lead_q   <= '0;
		end else if (accept) begin
			if (done) begin
				phase_q  <= PH_SEEK;
				ok_q     <= '0;
				stored_q <= '0;
				region_q <= '0;
				lead_q   <= '0;
			end else begin
				phase_q  <= phase_nxt;
				ok_q     <= ok_nxt;
				stored_q <= stored_nxt;
				region_q <= region_nxt;
				lead_q   <= lead_nxt;
			end
		end
	end

endmodule

### hdl/arpe_emitter.sv
// ----------------------------------------------------------------------------
// arpe_emitter
// Burst sequencer: reads the payload store one entry at a time (a lead burst
// sends a lone CR) and drives the output register, marking the last word.
// ----------------------------------------------------------------------------
module arpe_emitter #(
	parameter int PAYLOAD_DEPTH = arpe_pkg::PAYLOAD_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  arpe_pkg::burst_t                 burst,
	output logic                             idle,
	output logic [$clog2(PAYLOAD_DEPTH)-1:0] rd_addr,
	input  logic [7:0]                       rd_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       out_byte,
	output logic                             last_byte
);

	import arpe_pkg::*;

	localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_LOAD = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] emit_q;
	logic [CNT_W-1:0] cnt_q;
	logic             lead_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             last_q;
	logic             slot_free;
	logic             is_last;

	assign idle      = (state_q == S_IDLE);
	assign rd_addr   = emit_q[ADDR_W-1:0];
	assign slot_free = !out_valid_q || out_ready;
	assign is_last   = (emit_q + CNT_W'(1)) == cnt_q;

	// Sequencer: issue read, then load the word once the output slot frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			emit_q  <= '0;
			cnt_q   <= '0;
			lead_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (burst.start) begin
						emit_q  <= '0;
						cnt_q   <= burst.lead ? CNT_W'(1) : burst.cnt;
						lead_q  <= burst.lead;
						state_q <= burst.lead ? S_LOAD : S_READ;
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (slot_free) begin
						if (is_last) begin
							state_q <= S_IDLE;
						end else begin
							emit_q  <= emit_q + CNT_W'(1);
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_LOAD) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_LOAD) && slot_free) begin
			out_byte_q <= lead_q ? CH_CR : rd_data;
			last_q     <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q;

endmodule

### hdl/at_response_payload_extractor.sv
// Timing: a terminator LF starts a burst; each payload word is read from the
// store (S_READ) and then loaded into the output register (S_LOAD); the lone
// CR of the lead pattern skips the read. Throughput: 1 input word per cycle
// while no burst runs; in a burst, S_LOAD waits until the output slot frees.
// The store's registered read sets the burst rate.
// Reset: arst_n clears parser and sequencer state; payload store is not reset.
// ----------------------------------------------------------------------------
// at_response_payload_extractor
// Captures the payload after the first colon of a modem response and emits
// it once the "OK" CR LF terminator arrives.
// ----------------------------------------------------------------------------
module at_response_payload_extractor #(
	parameter int PAYLOAD_DEPTH = arpe_pkg::PAYLOAD_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_byte
);

	import arpe_pkg::*;

	localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);

	logic              accept;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;
	logic              idle;
	burst_t            burst;

	assign in_ready = idle;
	assign accept   = in_valid && in_ready;

	arpe_parser #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.burst   (burst)
	);

	arpe_ram #(
		.WIDTH(8),
		.DEPTH(PAYLOAD_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	arpe_emitter #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH)
	) u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.burst     (burst),
		.idle      (idle),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the AT response payload extractor. Modem responses
// go in as words: directed cases first, then random responses. A
// cycle-accurate-free tracker predicts the payload words and last flags.
// Every output word is compared in order against the tracker's predictions.
// ----------------------------------------------------------------------------

// Tracks the response stream and holds the payload words still owed
class rx_payload_tracker;
	logic [7:0]  term_seq [4];
	logic [7:0]  lead_seq [3];
	logic [1:0]  phase;
	int unsigned term_prog;
	int unsigned lead_prog;
	int unsigned stored;
	int unsigned region;
	logic [7:0]  store [arpe_pkg::PAYLOAD_DEPTH_DEF];
	logic [7:0]  owed_byte_q [$];
	logic        owed_last_q [$];
	int unsigned mismatches;
	int unsigned words_seen;

	function new();
		term_seq = '{arpe_pkg::CH_O, arpe_pkg::CH_K, arpe_pkg::CH_CR, arpe_pkg::CH_LF};
		lead_seq = '{arpe_pkg::CH_LF, arpe_pkg::CH_CR, arpe_pkg::CH_LF};
		mismatches = 0;
		words_seen = 0;
		clear_region();
	endfunction

	// Back to the state after reset; the store keeps its contents
	function void clear_region();
		phase = arpe_pkg::PH_SEEK;
		term_prog = 0;
		lead_prog = 0;
		stored = 0;
		region = 0;
	endfunction

	function int unsigned pending();
		return owed_byte_q.size();
	endfunction

	// One accepted input word
	function void take_rx(input logic [7:0] b);
		bit          done;
		int unsigned avail;
		int unsigned cnt;
		// terminator match; only 'O' can restart a partial match
		if (b == term_seq[term_prog])
			term_prog++;
		else
			term_prog = (b == arpe_pkg::CH_O) ? 1 : 0;
		done = (term_prog == 4);

		if (phase == arpe_pkg::PH_SEEK) begin
			if (b == arpe_pkg::CH_COLON)
				phase = arpe_pkg::PH_CAPTURE;
		end else begin
			if (region < 255)
				region++;
			if (lead_prog < arpe_pkg::LEAD_MATCHED)
				lead_prog = (b == lead_seq[lead_prog]) ? lead_prog + 1 : arpe_pkg::LEAD_FAILED;
			if (phase == arpe_pkg::PH_CAPTURE) begin
				if (b == arpe_pkg::CH_CR || b == arpe_pkg::CH_LF || b == arpe_pkg::CH_NUL)
					phase = arpe_pkg::PH_STOPPED;
				else if (stored < arpe_pkg::PAYLOAD_DEPTH_DEF) begin
					store[stored] = b;
					stored++;
				end
			end
		end

		// terminator done: owe the payload that precedes it
		if (done) begin
			if (phase != arpe_pkg::PH_SEEK) begin
				if (lead_prog == arpe_pkg::LEAD_MATCHED) begin
					owed_byte_q.push_back(arpe_pkg::CH_CR);
					owed_last_q.push_back(1'b1);
				end else begin
					avail = (region >= 4) ? region - 4 : 0;
					cnt = (stored > avail) ? avail : stored;
					for (int unsigned i = 0; i < cnt; i++) begin
						owed_byte_q.push_back(store[i]);
						owed_last_q.push_back(i + 1 == cnt);
					end
				end
			end
			clear_region();
		end
	endfunction

	// One accepted output word
	function void match_word(input logic [7:0] b, input logic l);
		logic [7:0] eb;
		logic       el;
		words_seen++;
		if (owed_byte_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("word %0d: none expected, got %02h last %0b", words_seen, b, l);
		end else begin
			eb = owed_byte_q.pop_front();
			el = owed_last_q.pop_front();
			if (b !== eb || l !== el) begin
				mismatches++;
				if (mismatches <= 10)
					$display("word %0d: expected %02h last %0b, got %02h last %0b",
						words_seen, eb, el, b, l);
			end
		end
	endfunction
endclass

module tb_top;

	localparam int HALF_PERIOD = 6;
	localparam int RAND_WORDS  = 55;
	localparam int QUIET_AFTER = 40;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       last_byte;

	bit          quiet = 1'b0;
	int unsigned rx_sent = 0;

	rx_payload_tracker tracker = new();

	at_response_payload_extractor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

	always #HALF_PERIOD clk = ~clk;

	// Send one word, with an occasional idle burst ahead of it
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (!quiet && $urandom_range(0, 99) < 25) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		tracker.take_rx(b);
		rx_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_term();
		send_byte(arpe_pkg::CH_O);
		send_byte(arpe_pkg::CH_K);
		send_byte(arpe_pkg::CH_CR);
		send_byte(arpe_pkg::CH_LF);
	endtask

	// Random byte that does not end a capture
	function automatic logic [7:0] capture_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == arpe_pkg::CH_CR || b == arpe_pkg::CH_LF || b == arpe_pkg::CH_NUL);
		return b;
	endfunction

	function automatic logic [7:0] non_colon_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == arpe_pkg::CH_COLON);
		return b;
	endfunction

	task automatic send_payload(input int n);
		for (int i = 0; i < n; i++)
			send_byte(capture_byte());
	endtask

	task automatic send_junk(input int n);
		for (int i = 0; i < n; i++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	// Random response: mostly well formed, some without colon, broken or noise
	task automatic send_random_response();
		int kind;
		int len;
		int stop;
		kind = $urandom_range(0, 99);
		if (kind < 62) begin
			for (int i = $urandom_range(0, 4); i > 0; i--)
				send_byte(non_colon_byte());
			send_byte(arpe_pkg::CH_COLON);
			if ($urandom_range(0, 9) == 0) begin
				send_byte(arpe_pkg::CH_LF);
				send_byte(arpe_pkg::CH_CR);
				send_byte(arpe_pkg::CH_LF);
			end
			len = ($urandom_range(0, 99) < 8) ? $urandom_range(40, 70) : $urandom_range(0, 12);
			send_payload(len);
			stop = $urandom_range(0, 3);
			case (stop)
				0: send_byte(arpe_pkg::CH_CR);
				1: send_byte(arpe_pkg::CH_LF);
				2: send_byte(arpe_pkg::CH_NUL);
				default: ;
			endcase
			if (stop != 3)
				send_junk($urandom_range(0, 3));
			send_term();
		end else if (kind < 77) begin
			for (int i = $urandom_range(0, 6); i > 0; i--)
				send_byte(non_colon_byte());
			send_term();
		end else if (kind < 90) begin
			// broken terminator, the region carries on
			send_byte(arpe_pkg::CH_COLON);
			send_payload($urandom_range(0, 5));
			send_byte(arpe_pkg::CH_O);
			if ($urandom_range(0, 1)) begin
				send_byte(arpe_pkg::CH_K);
				send_byte(arpe_pkg::CH_CR);
			end
			send_byte(capture_byte());
		end else begin
			send_junk($urandom_range(1, 8));
		end
	endtask

	// Output side: ready drops in random bursts until the quiet tail
	initial begin
		int n;
		forever begin
			if (!quiet && $urandom_range(0, 99) < 35) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 18);
			end else begin
				out_ready <= 1'b1;
				n = $urandom_range(1, 24);
			end
			repeat (n) @(posedge clk);
		end
	end

	// Compare every accepted output word
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.match_word(out_byte, last_byte);
	end

	// Stimulus and end of run
	initial begin
		int unsigned base;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// basic payload stopped by CR
		send_text("+X:AB\r\n");
		send_term();
		// no colon: nothing comes out
		send_text("ATE0\r\n");
		send_term();
		// colon with empty capture
		send_text(":\r\n");
		send_term();
		// LF CR LF right after the colon gives a lone CR
		send_text(":\n\r\n");
		send_term();
		// only the terminator letters are captured
		send_text(":");
		send_term();
		// byte extremes, NUL stop
		send_byte(arpe_pkg::CH_COLON);
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'h80);
		send_byte(arpe_pkg::CH_NUL);
		send_byte(8'h7F);
		send_term();
		// LF stop
		send_text(":Z\n");
		send_term();
		// partial terminator inside the region, overlapping O
		send_text(":Q OK\rXOO");
		send_term();
		// second colon is captured
		send_text("a:b:c\r");
		send_term();
		// store full
		send_byte(arpe_pkg::CH_COLON);
		send_payload(66);
		send_byte(arpe_pkg::CH_CR);
		send_term();

		// random responses
		base = rx_sent;
		while (rx_sent - base < RAND_WORDS) begin
			if (rx_sent - base >= QUIET_AFTER)
				quiet = 1'b1;
			send_random_response();
		end
		quiet = 1'b1;
		send_text(":END");
		send_term();
		in_valid <= 1'b0;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#(2 * HALF_PERIOD * 600000);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
hdl/arpe_pkg.sv
hdl/arpe_ram.sv
hdl/arpe_parser.sv
hdl/arpe_emitter.sv
hdl/at_response_payload_extractor.sv
tb/sv/tb_top.sv
